@@ rtl/core/qpld_pkg.sv @@
// Shared types, constants and helper functions for the quoted-printable line decoder.
`default_nettype none

package qpld_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned ClsW  = 5;

  localparam logic [ByteW-1:0] QpEquals  = 8'h3D;
  localparam logic [ByteW-1:0] QpNewline = 8'h0A;

  // first-byte classes after '=': 0..15 hex value, then these
  localparam logic [ClsW-1:0] ClsNone  = 5'd16;  // also "not hex" for a nibble
  localparam logic [ClsW-1:0] ClsSpace = 5'd16;
  localparam logic [ClsW-1:0] ClsPlus  = 5'd17;
  localparam logic [ClsW-1:0] ClsMinus = 5'd18;
  localparam logic [ClsW-1:0] ClsOther = 5'd19;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_EQ    = 2'd1,
    PH_DIGIT = 2'd2
  } phase_e;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_EOL  = 1'b1
  } req_e;

  typedef struct packed {
    logic              emit;
    logic [ByteW-1:0]  data;
    logic              last;
    phase_e            phase;
    logic [ClsW-1:0]   cls;
  } dec_t;

  // hex value of a character, ClsNone when not a hex digit
  function automatic logic [ClsW-1:0] hex_nibble(input logic [ByteW-1:0] c);
    logic [ClsW-1:0] r;
    r = ClsNone;
    if (c >= 8'h30 && c <= 8'h39) r = ClsW'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) r = ClsW'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) r = ClsW'(c - 8'h61 + 8'd10);
    return r;
  endfunction

  function automatic logic [ClsW-1:0] classify(input logic [ByteW-1:0] c);
    logic [ClsW-1:0] h;
    logic [ClsW-1:0] r;
    h = hex_nibble(c);
    if (!h[ClsW-1]) r = h;
    else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) r = ClsSpace;
    else if (c == 8'h2B) r = ClsPlus;
    else if (c == 8'h2D) r = ClsMinus;
    else r = ClsOther;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/quoted_printable_line_decoder_unit.sv @@
// Quoted-printable line decoder top level: input register, decode step, result register.
// A request goes from the input register through the decode step into the result register.
// Throughput: one request per cycle; s_axis_tready drops only when both stages hold
// items and the result is not being taken.
// Reset (rst_ni low, asynchronous): both stages empty, escape state cleared.
`default_nettype none

module quoted_printable_line_decoder_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [qpld_pkg::ByteW-1:0]  s_axis_tdata,   // [7:0] in_byte
  input  wire logic                        s_axis_tuser,   // [0] req_type
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [qpld_pkg::ByteW-1:0]  m_axis_tdata,   // [7:0] out_byte
  output      logic                        m_axis_tlast    // line_done
);

  logic                        in_valid_q;
  logic                        in_type_q;
  logic [qpld_pkg::ByteW-1:0]  in_byte_q;
  qpld_pkg::phase_e            phase_q;
  logic [qpld_pkg::ClsW-1:0]   cls_q;
  logic                        out_valid_q;
  logic [qpld_pkg::ByteW-1:0]  out_byte_q;
  logic                        out_last_q;

  logic            out_free;
  logic            fire;
  logic            s_acc;
  qpld_pkg::dec_t  dec;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  qpld_decode u_decode (
    .phase_i    (phase_q),
    .cls_i      (cls_q),
    .req_type_i (in_type_q),
    .in_byte_i  (in_byte_q),
    .dec_o      (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= qpld_pkg::PH_IDLE;
      cls_q       <= '0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= dec.emit;
        phase_q     <= dec.phase;
        cls_q       <= dec.cls;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_type_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (fire && dec.emit) begin
      out_byte_q <= dec.data;
      out_last_q <= dec.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  a_last_is_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == qpld_pkg::QpNewline)
    else $error("line end result is not a newline");

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_type_q |=> phase_q == qpld_pkg::PH_IDLE)
    else $error("escape state survives a line end");

  a_eq_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !in_type_q && phase_q == qpld_pkg::PH_EQ |=> phase_q == qpld_pkg::PH_DIGIT)
    else $error("escape did not advance after first byte");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q && !m_axis_tready)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ rtl/core/qpld_decode.sv @@
// Combinational decode step: escape state plus one request gives next state and result.
`default_nettype none

module qpld_decode (
  input  var qpld_pkg::phase_e                 phase_i,
  input  wire logic [qpld_pkg::ClsW-1:0]       cls_i,
  input  wire logic                            req_type_i,
  input  wire logic [qpld_pkg::ByteW-1:0]      in_byte_i,
  output qpld_pkg::dec_t                       dec_o
);

  logic [qpld_pkg::ClsW-1:0]  h;
  logic [qpld_pkg::ByteW-1:0] pair_val;
  logic                       pair_ok;

  assign h = qpld_pkg::hex_nibble(in_byte_i);

  // hex pair read the way a two-wide hex scan conversion reads it
  always_comb begin
    pair_ok  = 1'b1;
    pair_val = '0;
    if (!cls_i[qpld_pkg::ClsW-1]) begin
      pair_val = h[qpld_pkg::ClsW-1] ? {4'h0, cls_i[3:0]} : {cls_i[3:0], h[3:0]};
    end else if (h[qpld_pkg::ClsW-1]) begin
      pair_ok = 1'b0;
    end else if (cls_i == qpld_pkg::ClsSpace || cls_i == qpld_pkg::ClsPlus) begin
      pair_val = {4'h0, h[3:0]};
    end else if (cls_i == qpld_pkg::ClsMinus) begin
      pair_val = 8'h00 - {4'h0, h[3:0]};
    end else begin
      pair_ok = 1'b0;
    end
  end

  always_comb begin
    dec_o       = '0;
    dec_o.phase = qpld_pkg::PH_IDLE;
    if (req_type_i == qpld_pkg::REQ_EOL) begin
      // '=' closing a line is a soft break
      if (phase_i != qpld_pkg::PH_EQ) begin
        dec_o.emit = 1'b1;
        dec_o.data = qpld_pkg::QpNewline;
        dec_o.last = 1'b1;
      end
    end else begin
      case (phase_i)
        qpld_pkg::PH_EQ: begin
          dec_o.phase = qpld_pkg::PH_DIGIT;
          dec_o.cls   = qpld_pkg::classify(in_byte_i);
        end
        qpld_pkg::PH_DIGIT: begin
          dec_o.emit = pair_ok && (pair_val != '0);
          dec_o.data = pair_val;
        end
        default: begin
          if (in_byte_i == qpld_pkg::QpEquals) begin
            dec_o.phase = qpld_pkg::PH_EQ;
          end else begin
            dec_o.emit = 1'b1;
            dec_o.data = in_byte_i;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_quoted_printable_line_decoder_unit.sv @@
// Stream testbench for the quoted-printable line decoder: directed and random requests, self-checking.
`default_nettype none

module tb_quoted_printable_line_decoder_unit;

  localparam int unsigned ByteW      = qpld_pkg::ByteW;
  localparam int unsigned ClsW       = qpld_pkg::ClsW;
  localparam int unsigned NumReqs    = 950;
  localparam int unsigned TailReqs   = 120;
  localparam int unsigned LongHold   = 64;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxPrints  = 30;

  typedef struct {
    qpld_pkg::req_e   kind;
    logic [ByteW-1:0] ch;
    bit               drain;  // not a request: pause until all results are back
  } enc_req_t;

  typedef struct {
    logic [ByteW-1:0] ch;
    logic             done;
  } dec_byte_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  enc_req_t  enc_stream[$];
  dec_byte_t decoded_q[$];

  // decoder state as predicted
  qpld_pkg::phase_e esc_phase = qpld_pkg::PH_IDLE;
  logic [ClsW-1:0]  esc_cls = '0;

  int unsigned total_reqs = 0;
  int unsigned eol_reqs = 0;
  int unsigned reqs_accepted = 0;
  int unsigned reqs_in_flight = 0;  // NBA copy for the receiver side
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          long_hold_done = 1'b0;
  bit          tail_mode = 1'b0;

  quoted_printable_line_decoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  task automatic report_mismatch(input string msg);
    if (errors < MaxPrints) $display("ERROR @%0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  task automatic queue_req(input qpld_pkg::req_e kind, input logic [ByteW-1:0] ch,
                           input bit drain);
    enc_req_t r;
    r.kind  = kind;
    r.ch    = ch;
    r.drain = drain;
    enc_stream.insert(enc_stream.size(), r);
  endtask

  task automatic queue_result(input logic [ByteW-1:0] ch, input logic done);
    dec_byte_t d;
    d.ch   = ch;
    d.done = done;
    decoded_q.insert(decoded_q.size(), d);
  endtask

  // ---------------------------------------------------------------- prediction

  function automatic logic [ClsW-1:0] hex_digit_val(input logic [ByteW-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return ClsW'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return ClsW'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return ClsW'(c - 8'h61 + 8'd10);
    return qpld_pkg::ClsNone;
  endfunction

  function automatic logic [ClsW-1:0] lead_class(input logic [ByteW-1:0] c);
    logic [ClsW-1:0] h;
    h = hex_digit_val(c);
    if (h < 5'd16) return h;
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return qpld_pkg::ClsSpace;
    if (c == 8'h2B) return qpld_pkg::ClsPlus;
    if (c == 8'h2D) return qpld_pkg::ClsMinus;
    return qpld_pkg::ClsOther;
  endfunction

  task automatic decode_req(input qpld_pkg::req_e kind, input logic [ByteW-1:0] c);
    qpld_pkg::phase_e ph;
    logic [ClsW-1:0]  h;
    logic [ByteW-1:0] v;
    bit               ok;
    ph = esc_phase;
    ok = 1'b0;
    v = '0;
    if (kind == qpld_pkg::REQ_EOL) begin
      esc_phase = qpld_pkg::PH_IDLE;
      esc_cls = '0;
      // '=' right before the line end is a soft break
      if (ph != qpld_pkg::PH_EQ) queue_result(qpld_pkg::QpNewline, 1'b1);
    end else begin
      case (ph)
        qpld_pkg::PH_EQ: begin
          esc_cls = lead_class(c);
          esc_phase = qpld_pkg::PH_DIGIT;
        end
        qpld_pkg::PH_DIGIT: begin
          esc_phase = qpld_pkg::PH_IDLE;
          h = hex_digit_val(c);
          if (esc_cls < 5'd16) begin
            ok = 1'b1;
            v = (h < 5'd16) ? {esc_cls[3:0], h[3:0]} : {4'h0, esc_cls[3:0]};
          end else if (h < 5'd16) begin
            if (esc_cls == qpld_pkg::ClsSpace || esc_cls == qpld_pkg::ClsPlus) begin
              ok = 1'b1;
              v = {4'h0, h[3:0]};
            end else if (esc_cls == qpld_pkg::ClsMinus) begin
              ok = 1'b1;
              v = 8'h00 - {4'h0, h[3:0]};
            end
          end
          if (ok && v != 8'h00) queue_result(v, 1'b0);
          esc_cls = '0;
        end
        default: begin
          if (c == qpld_pkg::QpEquals) esc_phase = qpld_pkg::PH_EQ;
          else queue_result(c, 1'b0);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [ByteW-1:0] c);
    queue_req(qpld_pkg::REQ_BYTE, c, 1'b0);
    total_reqs++;
  endtask

  task automatic push_eol();
    // payload is don't-care on a line end; keep it random
    queue_req(qpld_pkg::REQ_EOL, ByteW'($urandom_range(0, 255)), 1'b0);
    total_reqs++;
    eol_reqs++;
  endtask

  task automatic push_esc(input logic [ByteW-1:0] a, input logic [ByteW-1:0] b);
    push_byte(qpld_pkg::QpEquals);
    push_byte(a);
    push_byte(b);
  endtask

  function automatic logic [ByteW-1:0] esc_char();
    string hexset;
    int    sel;
    hexset = "0123456789abcdefABCDEF";
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3, 4: return hexset[$urandom_range(0, 21)];
      5: begin
        if ($urandom_range(0, 1)) return 8'h20;
        return ByteW'($urandom_range(9, 13));
      end
      6: return 8'h2B;
      7: return 8'h2D;
      8: return 8'h30;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] plain_char();
    logic [ByteW-1:0] c;
    c = ByteW'($urandom_range(0, 255));
    if (c == qpld_pkg::QpEquals) c = 8'h41;
    return c;
  endfunction

  task automatic gen_line();
    int n;
    int sel;
    n = $urandom_range(0, 12);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 6) push_byte(plain_char());
      else push_esc(esc_char(), esc_char());
    end
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      push_byte(qpld_pkg::QpEquals);
    end else if (sel == 2) begin
      push_byte(qpld_pkg::QpEquals);
      push_byte(esc_char());
    end
    push_eol();
  endtask

  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) push_eol();
      else if ($urandom_range(0, 3) == 0) push_byte(qpld_pkg::QpEquals);
      else push_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    enc_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        reqs_accepted++;
        decode_req(qpld_pkg::req_e'(s_axis_tuser), s_axis_tdata);
      end
      reqs_in_flight <= reqs_accepted;
      tail_mode <= (total_reqs - reqs_accepted <= TailReqs);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (enc_stream.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (enc_stream[0].drain) begin
          if (decoded_q.size() == 0) void'(enc_stream.pop_front());
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = enc_stream.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.kind;
          s_axis_tdata  <= nxt.ch;
          if (!tail_mode && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 11);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && reqs_in_flight >= 300) begin
      // long hold-off: both stages fill and the input stalls
      long_hold_done <= 1'b1;
      stall_left <= LongHold - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 10);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dec_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%02h last=%0b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = decoded_q.pop_front();
        results_checked++;
        if (m_axis_tdata !== want.ch || m_axis_tlast !== want.done)
          report_mismatch($sformatf("result byte=%02h last=%0b, expected byte=%02h last=%0b",
                                    m_axis_tdata, m_axis_tlast, want.ch, want.done));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    bit timed_out;
    timed_out = 1'b0;

    // directed: extremes, escapes, soft break and broken escapes
    push_eol();                      // empty line
    push_byte(8'h00);
    push_byte(8'hFF);
    push_esc(8'h66, 8'h46);          // "=fF" -> 0xFF
    push_esc(8'h30, 8'h30);          // "=00" decodes to zero, dropped
    push_esc(8'h33, 8'h44);          // "=3D" is a plain '=' afterwards
    push_byte(qpld_pkg::QpEquals);   // soft break
    push_eol();
    push_byte(qpld_pkg::QpEquals);   // '=' plus one byte at line end: both dropped
    push_byte(8'h34);
    push_eol();
    push_esc(8'h20, 8'h37);          // blank lead
    push_esc(8'h2B, 8'h39);          // '+' lead
    push_esc(8'h2D, 8'h31);          // '-' lead -> 0xFF

    while (total_reqs < NumReqs) begin
      if (total_reqs >= NumReqs / 2 && total_reqs < NumReqs / 2 + 20)
        queue_req(qpld_pkg::REQ_BYTE, 8'h00, 1'b1);
      if ($urandom_range(0, 99) < 15) gen_noise();
      else gen_line();
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((reqs_accepted < total_reqs || decoded_q.size() != 0) && cycle_cnt < CycleLimit)
      @(posedge clk_i);
    timed_out = (cycle_cnt >= CycleLimit);
    repeat (6) @(posedge clk_i);
    if (decoded_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", decoded_q.size()));

    $display("Covered %0d requests (%0d line ends) incl. escapes, soft breaks and stalls;",
             reqs_accepted, eol_reqs);
    $display("%0d decoded results checked, %0d mismatches.", results_checked, errors);
    if (!timed_out && errors == 0) begin
      $display("quoted_printable_line_decoder_unit test passed");
    end else begin
      $display("quoted_printable_line_decoder_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/qpld_pkg.sv
rtl/core/qpld_decode.sv
rtl/core/quoted_printable_line_decoder_unit.sv
sim/tb_quoted_printable_line_decoder_unit.sv
